>>> hdl/binary_to_decimal_ascii_assert.svh
// assertion helpers for the binary to decimal ascii converter
// each macro takes a label, an antecedent and a consequent
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define BDA_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("binary_to_decimal_ascii: same-cycle check failed");
`define BDA_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("binary_to_decimal_ascii: next-cycle check failed");
`else
`define BDA_ASSERT_SAME(lbl, ant, cons)
`define BDA_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

>>> hdl/bda_pkg.sv
`default_nettype none

package bda_pkg;

    // width mode codes
    localparam logic [1:0] WMODE_8  = 2'd0;
    localparam logic [1:0] WMODE_16 = 2'd1;
    localparam logic [1:0] WMODE_32 = 2'd2;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITS_PER_CYCLE = 4;
    localparam int DD_CYCLES  = VALUE_W / BITS_PER_CYCLE;
    localparam int ITER_W     = $clog2(DD_CYCLES);

    // one converted item on its way from front to back
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [1:0]       wmode;
        logic             sgn;
        logic             neg;
    } entry_t;

    // one double-dabble step: add 3 to digits of 5 or more, shift in one bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

`default_nettype wire

>>> hdl/bda_front.sv
`default_nettype none

module bda_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [31:0]     value_in,
    input  wire logic [1:0]      width_mode,
    input  wire logic            is_signed,
    output logic                 push_valid,
    output bda_pkg::entry_t      push_entry,
    input  wire logic            q_full
);
    import bda_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DD_CYCLES - 1);

    logic [1:0]         state_reg, state_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [1:0]         wmode_reg, wmode_next;
    logic               sgn_reg, sgn_next;
    logic               neg_reg, neg_next;

    logic [VALUE_W-1:0] masked, mask, negated, mag;
    logic [1:0]         norm_mode;
    logic               sign_bit, neg_in;
    logic [BCD_W-1:0]   s1, s2, s3, s4;

    // classify the incoming item
    always_comb
    begin
        unique case (width_mode)
            WMODE_8:
            begin
                masked    = {24'b0, value_in[7:0]};
                mask      = 32'h0000_00FF;
                sign_bit  = value_in[7];
                norm_mode = WMODE_8;
            end
            WMODE_16:
            begin
                masked    = {16'b0, value_in[15:0]};
                mask      = 32'h0000_FFFF;
                sign_bit  = value_in[15];
                norm_mode = WMODE_16;
            end
            default:
            begin
                masked    = value_in;
                mask      = 32'hFFFF_FFFF;
                sign_bit  = value_in[31];
                norm_mode = WMODE_32;
            end
        endcase
        neg_in  = is_signed & sign_bit;
        negated = 32'd0 - masked;
        mag     = neg_in ? (negated & mask) : masked;
    end

    // four double-dabble steps per cycle, msb first
    always_comb
    begin
        s1 = dd_step(bcd_reg, bin_reg[VALUE_W-1]);
        s2 = dd_step(s1, bin_reg[VALUE_W-2]);
        s3 = dd_step(s2, bin_reg[VALUE_W-3]);
        s4 = dd_step(s3, bin_reg[VALUE_W-4]);
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        wmode_next = wmode_reg;
        sgn_next   = sgn_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_CONV;
                    iter_next  = '0;
                    bin_next   = mag;
                    bcd_next   = '0;
                    wmode_next = norm_mode;
                    sgn_next   = is_signed;
                    neg_next   = neg_in;
                end
            end
            F_CONV:
            begin
                bcd_next  = s4;
                bin_next  = bin_reg << BITS_PER_CYCLE;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        wmode_reg <= wmode_next;
        sgn_reg   <= sgn_next;
        neg_reg   <= neg_next;
    end

    assign in_stall         = (state_reg != F_IDLE);
    assign push_valid       = (state_reg == F_PUSH);
    assign push_entry.bcd   = bcd_reg;
    assign push_entry.wmode = wmode_reg;
    assign push_entry.sgn   = sgn_reg;
    assign push_entry.neg   = neg_reg;

endmodule

`default_nettype wire

>>> hdl/bda_queue.sv
`default_nettype none

module bda_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire bda_pkg::entry_t  push_entry,
    output logic                  full,
    output logic                  head_valid,
    output bda_pkg::entry_t       head_entry,
    input  wire logic             pop
);
    import bda_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push_valid & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bda_back.sv
`default_nettype none

module bda_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire bda_pkg::entry_t  head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            ascii_char,
    output logic [3:0]            char_position,
    output logic                  last_char
);
    import bda_pkg::*;

    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [3:0]       left_reg, left_next;
    logic [3:0]       pos_reg, pos_next;
    logic             sign_pend_reg, sign_pend_next;
    logic             neg_reg, neg_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       char_reg, char_next;
    logic [3:0]       opos_reg, opos_next;
    logic             last_reg, last_next;

    logic             active, out_ready, emit, final_emit;
    logic [BCD_W-1:0] aligned;
    logic [3:0]       ndig;

    assign active     = sign_pend_reg | (left_reg != 4'd0);
    assign out_ready  = ~out_valid_reg | ~out_stall;
    assign emit       = active & out_ready;
    assign final_emit = emit & ~sign_pend_reg & (left_reg == 4'd1);
    assign pop        = head_valid & (~active | final_emit);

    // left-align the used digits so the first one sits on top
    always_comb
    begin
        unique case (head_entry.wmode)
            WMODE_8:
            begin
                aligned = head_entry.bcd << 28;
                ndig    = 4'd3;
            end
            WMODE_16:
            begin
                aligned = head_entry.bcd << 20;
                ndig    = 4'd5;
            end
            default:
            begin
                aligned = head_entry.bcd;
                ndig    = 4'd10;
            end
        endcase
    end

    always_comb
    begin
        bcd_next       = bcd_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        sign_pend_next = sign_pend_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg & out_stall;
        char_next      = char_reg;
        opos_next      = opos_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            opos_next      = pos_reg;
            pos_next       = pos_reg + 4'd1;
            if (sign_pend_reg)
            begin
                char_next      = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                last_next      = 1'b0;
                sign_pend_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO + {4'b0, bcd_reg[BCD_W-1 -: 4]};
                last_next = (left_reg == 4'd1);
                bcd_next  = bcd_reg << 4;
                left_next = left_reg - 4'd1;
            end
        end

        // next item loads over the finished one
        if (pop)
        begin
            bcd_next       = aligned;
            left_next      = ndig;
            pos_next       = 4'd0;
            sign_pend_next = head_entry.sgn;
            neg_next       = head_entry.neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= 4'd0;
            pos_reg       <= 4'd0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign ascii_char    = char_reg;
    assign char_position = opos_reg;
    assign last_char     = last_reg;

endmodule

`default_nettype wire

>>> hdl/binary_to_decimal_ascii.sv
// binary to fixed-width decimal ascii: each input transfer carries a value, a width mode
// (8, 16 or 32 bits, mode 3 acts as 32) and a signed flag, and yields 3, 5 or 10
// zero-padded digits, one character per output transfer, preceded by '+' or '-' in signed
// mode (zero gets '+', the most negative value prints its exact magnitude). every character
// carries its position in the string and the final one has last_char set. the front accepts
// an item while idle, converts it four bits at a time by double dabble and then hands the
// digits to the queue, waiting while the queue is full, and stalls new input meanwhile. the
// back emits one character per cycle while the output is not stalled. the queue lets the
// front convert the next value while the back is still sending characters of earlier ones.
`default_nettype none

`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] value_in,
    input  wire logic [1:0]  width_mode,
    input  wire logic        is_signed,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       ascii_char,
    output logic [3:0]       char_position,
    output logic             last_char
);
    import bda_pkg::*;

    // front to queue
    logic   push_valid;
    entry_t push_entry;
    logic   q_full;

    // queue to back
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    // output character classes seen by the checks below
    logic   is_digit_char;
    logic   is_sign_char;
    logic   last_len_ok;

    // classification and binary to bcd conversion
    bda_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_in   (value_in),
        .width_mode (width_mode),
        .is_signed  (is_signed),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // short queue of converted items
    bda_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // character sequencer with output register
    bda_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ascii_char    (ascii_char),
        .char_position (char_position),
        .last_char     (last_char)
    );

    assign is_digit_char = (ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE);
    assign is_sign_char  = (ascii_char == CHAR_PLUS) || (ascii_char == CHAR_MINUS);
    // last positions of 3, 4, 5, 6, 10 and 11 character strings
    assign last_len_ok   = (char_position == 4'd2) || (char_position == 4'd3) ||
                           (char_position == 4'd4) || (char_position == 4'd5) ||
                           (char_position == 4'd9) || (char_position == 4'd10);

    // characters of one string leave without gaps once the output moves
    `BDA_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last_char, out_valid)
    // the final character is a digit at a legal string length
    `BDA_ASSERT_SAME(a_last_digit, out_valid && last_char, is_digit_char && last_len_ok)
    // a sign only ever opens a string
    `BDA_ASSERT_SAME(a_sign_first, out_valid && is_sign_char, char_position == 4'd0 && !last_char)

endmodule

`default_nettype wire

>>> tb/tb_binary_to_decimal_ascii.sv
`default_nettype none

module tb_binary_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    // the package names modes 0..2 only, the spare code converts like 32-bit
    localparam logic [1:0] WMODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 340;
    localparam int MAX_WAIT     = 12;
    // receiver hold-off long enough to fill the converter and its queue
    localparam int LONG_HOLD    = 200;
    // idle cycles with no transfer on either side before the run is abandoned
    localparam int IDLE_LIMIT   = 2000;
    // cycles allowed after the last expected character for stray output
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 100;

    // one conversion request as the sender offers it
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  wmode;
        logic        sgn;
    } conv_item_t;

    // one character the converter must produce
    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] pos;
        logic       last;
    } char_exp_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel, known from time zero
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [31:0] value_in   = '0;
    logic [1:0]  width_mode = WMODE_8;
    logic        is_signed  = 1'b0;

    // output channel
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  ascii_char;
    logic [3:0]  char_position;
    logic        last_char;

    // requests waiting to be offered and characters waiting to arrive
    conv_item_t pending_items[$];
    char_exp_t  expected_chars[$];

    int  items_queued    = 0;
    int  items_accepted  = 0;
    int  chars_received  = 0;
    int  mismatch_count  = 0;
    int  send_gap        = 0;
    int  hold_left       = 0;
    bit  send_quiet      = 1'b0;
    bit  recv_quiet      = 1'b0;

    binary_to_decimal_ascii dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value_in      (value_in),
        .width_mode    (width_mode),
        .is_signed     (is_signed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ascii_char    (ascii_char),
        .char_position (char_position),
        .last_char     (last_char)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one printed line per mismatch, the log is capped to stay readable
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // a wait of 0 to MAX_WAIT, or none at all inside a quiet stretch
    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_item(input logic [31:0] value, input logic [1:0] wmode,
                              input logic sgn);
        conv_item_t it;
        it.value = value;
        it.wmode = wmode;
        it.sgn   = sgn;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // expected string of one accepted request: optional sign, then zero-padded digits
    function automatic void predict_string(input logic [31:0] value, input logic [1:0] wmode,
                                           input logic sgn);
        logic [31:0] mask;
        logic [31:0] sign_bit;
        logic [31:0] mag;
        logic [3:0]  digit [10];
        int          ndig;
        int          pos;
        bit          neg;
        char_exp_t   e;
        case (wmode)
            WMODE_8:
            begin
                mask = 32'h0000_00FF; sign_bit = 32'h0000_0080; ndig = 3;
            end
            WMODE_16:
            begin
                mask = 32'h0000_FFFF; sign_bit = 32'h0000_8000; ndig = 5;
            end
            default:
            begin
                mask = 32'hFFFF_FFFF; sign_bit = 32'h8000_0000; ndig = 10;
            end
        endcase
        mag = value & mask;
        neg = sgn && ((mag & sign_bit) != 0);
        // two's-complement negation within the width, exact for the most negative value
        if (neg)
        begin
            mag = (~mag + 32'd1) & mask;
        end
        pos = 0;
        if (sgn)
        begin
            e.ch   = neg ? CHAR_MINUS : CHAR_PLUS;
            e.pos  = 4'd0;
            e.last = 1'b0;
            expected_chars.push_back(e);
            pos = 1;
        end
        // digits come out least significant first, so fill from the right
        for (int i = 0; i < ndig; i++)
        begin
            digit[ndig - 1 - i] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
        end
        for (int i = 0; i < ndig; i++)
        begin
            e.ch   = CHAR_ZERO + digit[i];
            e.pos  = 4'(pos);
            e.last = (i == ndig - 1);
            expected_chars.push_back(e);
            pos++;
        end
    endfunction

    // sender: offers queued requests, waits a drawn gap after every transfer,
    // holds the payload steady while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            conv_item_t it;
            if (in_valid && !in_stall)
            begin
                // transfer on the input: the expected string is known from here on
                predict_string(value_in, width_mode, is_signed);
                items_accepted++;
                if ($urandom_range(0, 15) == 0)
                begin
                    send_quiet = !send_quiet;
                end
                send_gap = draw_wait(send_quiet);
            end
            else if (!in_valid && send_gap > 0)
            begin
                send_gap--;
            end

            if (in_valid && in_stall)
            begin
                // stalled: keep offering the same request
            end
            else if (send_gap == 0 && pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                value_in   <= it.value;
                width_mode <= it.wmode;
                is_signed  <= it.sgn;
                in_valid   <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks every character transfer against the oldest expectation,
    // then stalls for a drawn number of cycles before taking the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            char_exp_t e;
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h at position %0d",
                                              ascii_char, char_position));
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (ascii_char !== e.ch)
                    begin
                        report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                                  ascii_char, e.ch));
                    end
                    if (char_position !== e.pos)
                    begin
                        report_mismatch($sformatf("char_position %0d, expected %0d",
                                                  char_position, e.pos));
                    end
                    if (last_char !== e.last)
                    begin
                        report_mismatch($sformatf("last_char %0b, expected %0b at position %0d",
                                                  last_char, e.last, e.pos));
                    end
                end
                chars_received++;
                // two long hold-offs let the sender back up into the converter
                if (chars_received == 150 || chars_received == 1500)
                begin
                    hold_left = LONG_HOLD;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        recv_quiet = !recv_quiet;
                    end
                    hold_left = draw_wait(recv_quiet);
                end
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            out_stall <= (hold_left != 0);
        end
    end

    // watchdog: too long without any transfer means the converter has hung
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
            begin
                idle_cycles++;
            end
            else
            begin
                idle_cycles = 0;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        conv_item_t it;

        // 8-bit extremes, sign boundary and zero with its '+' sign
        queue_item(32'h0000_0000, WMODE_8, 1'b0);
        queue_item(32'h0000_00FF, WMODE_8, 1'b0);
        queue_item(32'h0000_0000, WMODE_8, 1'b1);
        queue_item(32'h0000_007F, WMODE_8, 1'b1);
        queue_item(32'h0000_0080, WMODE_8, 1'b1);
        queue_item(32'h0000_00FF, WMODE_8, 1'b1);
        // 16-bit
        queue_item(32'h0000_0000, WMODE_16, 1'b0);
        queue_item(32'h0000_FFFF, WMODE_16, 1'b0);
        queue_item(32'h0000_7FFF, WMODE_16, 1'b1);
        queue_item(32'h0000_8000, WMODE_16, 1'b1);
        queue_item(32'h0000_FFFF, WMODE_16, 1'b1);
        // 32-bit, most negative value included
        queue_item(32'h0000_0000, WMODE_32, 1'b0);
        queue_item(32'hFFFF_FFFF, WMODE_32, 1'b0);
        queue_item(32'h0000_0000, WMODE_32, 1'b1);
        queue_item(32'h7FFF_FFFF, WMODE_32, 1'b1);
        queue_item(32'h8000_0000, WMODE_32, 1'b1);
        queue_item(32'hFFFF_FFFF, WMODE_32, 1'b1);
        // spare mode converts as 32-bit
        queue_item(32'hFFFF_FFFF, WMODE_SPARE, 1'b0);
        queue_item(32'h8000_0000, WMODE_SPARE, 1'b1);
        // upper bits beyond the width must be ignored
        queue_item(32'hDEAD_BE80, WMODE_8, 1'b1);
        queue_item(32'h1234_8000, WMODE_16, 1'b0);

        // random part: mostly full-range values, some small, some around the sign bit
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it.wmode = 2'($urandom_range(0, 3));
            it.sgn   = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: it.value = $urandom_range(0, 20);
                1:
                begin
                    case (it.wmode)
                        WMODE_8:  it.value = 32'h0000_0080;
                        WMODE_16: it.value = 32'h0000_8000;
                        default:  it.value = 32'h8000_0000;
                    endcase
                    it.value = it.value + $urandom_range(0, 2) - 1;
                end
                default: it.value = $urandom();
            endcase
            queue_item(it.value, it.wmode, it.sgn);
        end

        // hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every request to be taken and every character to arrive
        @(negedge clk);
        while (items_accepted < items_queued || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
        // a little longer, so stray characters still get caught
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
